// ----- design/gsw_pkg.sv -----
// ----------------------------------------------------------------------------
// gsw_pkg
// Shared types, register codes and fixed-point helpers for the grid spring
// wave step block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsw_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed widths of the datapath
    localparam int DZW       = 35;   // sum of four 33-bit differences
    localparam int FRIC_BITS = 16;   // friction factor fraction bits
    localparam int CFG_IW    = 3;    // register index width
    localparam int CFG_DW    = 31;   // widest register

    // Register indexes
    localparam logic [CFG_IW-1:0] CFG_GRID_ROWS   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_COLS   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BORDER      = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SPRING_GAIN = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_FRICTION    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_MIN_SPEED   = 3'd5;

    typedef struct packed {
        logic signed [31:0] position;
        logic               locked;
    } item_t;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic               run_last;
        logic               frame_end;
    } result_t;

    typedef struct packed {
        logic [6:0]  grid_rows;
        logic [6:0]  grid_cols;
        logic [5:0]  border_width;
        logic [30:0] spring_gain;
        logic [16:0] friction_factor;
        logic [15:0] min_speed;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_ADDR,
        ST_MUL,
        ST_ACC,
        ST_FRIC,
        ST_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        JOB_UP,
        JOB_LEFT,
        JOB_CORNER
    } job_t;

    // Saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Exact difference a - b
    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return 33'(a) - 33'(b);
    endfunction

endpackage

`default_nettype wire

// ----- design/gsw_ram.sv -----
// ----------------------------------------------------------------------------
// gsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/gsw_queue.sv -----
// ----------------------------------------------------------------------------
// gsw_queue
// Two-entry queue that carries classified items from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gsw_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/gsw_front.sv -----
// ----------------------------------------------------------------------------
// gsw_front
// Accepts grid cells, tracks raster position and classifies each cell by
// row and column before handing it to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module gsw_front
    import gsw_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int RIW   = $clog2(MAX_ROWS),
    localparam int CIW   = $clog2(MAX_COLS),
    localparam int ERW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7,
    localparam int ECW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7,
    localparam int REC_W = 32 + 1 + RIW + CIW + 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire item_t            item,
    input  wire logic [ERW-1:0]   eff_rows,
    input  wire logic [ECW-1:0]   eff_cols,
    input  wire logic             clearing,
    input  wire logic             q_full,
    output logic                  q_push,
    output logic      [REC_W-1:0] q_data
);

    logic [RIW-1:0] row_reg, row_next;
    logic [CIW-1:0] col_reg, col_next;
    logic           last_row;
    logic           last_col;

    // Classify the current raster position
    assign last_row = (ERW'(row_reg) + ERW'(1)) >= eff_rows;
    assign last_col = (ECW'(col_reg) + ECW'(1)) >= eff_cols;

    // Hold off input during the clearing pass or when the queue is full
    assign item_stall = q_full || clearing;
    assign q_push     = item_valid && !item_stall;
    assign q_data     = {item.position, item.locked, row_reg, col_reg, last_row, last_col};

    // Advance raster counters on each beat
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (q_push)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RIW'(1);
            end
            else
            begin
                col_next = col_reg + CIW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/gsw_back.sv -----
// ----------------------------------------------------------------------------
// gsw_back
// Carries out queued cells: reads the stencil from the line buffer, runs up
// to three cell updates through a shared velocity unit and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module gsw_back
    import gsw_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RIW    = $clog2(MAX_ROWS),
    localparam int CIW    = $clog2(MAX_COLS),
    localparam int ERW    = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7,
    localparam int ECW    = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7,
    localparam int REC_W  = 32 + 1 + RIW + CIW + 2,
    localparam int LDEPTH = 2 * MAX_COLS,
    localparam int LAW    = $clog2(LDEPTH),
    localparam int VDEPTH = MAX_ROWS * MAX_COLS,
    localparam int VAW    = $clog2(VDEPTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic [ERW-1:0]   eff_rows,
    input  wire logic [ECW-1:0]   eff_cols,
    output logic                  clearing,
    input  wire logic             q_empty,
    input  wire logic [REC_W-1:0] q_data,
    output logic                  q_pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_t               result
);

    localparam int GHW = 31 - FRAC_BITS;
    localparam int PHW = DZW + GHW + 1;
    localparam int PLW = DZW + FRAC_BITS + 1;
    localparam int FPW = 32 + 18;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [VAW-1:0] clr_reg, clr_next;

    // Item working registers
    logic signed [31:0] z_reg, z_next;
    logic               lk_reg, lk_next;
    logic [RIW-1:0]     r_reg, r_next;
    logic [CIW-1:0]     c_reg, c_next;
    logic               lastr_reg, lastr_next;
    logic               lastc_reg, lastc_next;
    logic [32:0]        lbuf_reg [6];
    logic [32:0]        lbuf_next [6];

    // Cell update registers
    logic signed [DZW-1:0] dz_reg, dz_next;
    logic signed [31:0]    ctr_reg, ctr_next;
    logic                  kill_reg, kill_next;
    logic                  fe_reg, fe_next;
    logic                  last_reg, last_next;
    logic [VAW-1:0]        vaddr_reg, vaddr_next;
    logic signed [PHW-1:0] ph_reg, ph_next;
    logic signed [PLW-1:0] pl_reg, pl_next;
    logic signed [31:0]    vel_reg, vel_next;
    logic signed [31:0]    v_reg, v_next;
    logic signed [31:0]    np_reg, np_next;
    logic signed [FPW-1:0] fp_reg, fp_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // Memory ports
    logic           lwr_en;
    logic [LAW-1:0] lwr_addr;
    logic [LAW-1:0] lrd_addr;
    logic [32:0]    lrd_data;
    logic           vwr_en;
    logic [VAW-1:0] vwr_addr;
    logic [31:0]    vwr_data;
    logic [VAW-1:0] vrd_addr;
    logic [31:0]    vrd_data;

    // Stencil and job helpers
    logic           par;
    logic [CIW-1:0] cm1, cm2, cp1;
    logic           has_up, has_left, has_corner;
    logic signed [31:0]  j_ctr;
    logic signed [DZW-1:0] j_dz;
    logic           j_lock;
    logic [RIW-1:0] j_rr;
    logic [CIW-1:0] j_cc;
    logic           j_band;
    logic [VAW-1:0] j_vaddr;
    logic           j_more;
    job_t           j_follow;
    logic [GHW-1:0] gain_hi;
    logic [FRAC_BITS-1:0] gain_lo;
    logic [16:0]    fric_eff;
    logic signed [63:0] vsum;
    logic signed [31:0] vsat;
    logic signed [33:0] nv;
    logic signed [33:0] ms;
    logic signed [31:0] nv_st;
    logic           out_free;

    gsw_ram #(.WIDTH(33), .DEPTH(LDEPTH)) u_line_ram (
        .clk     (clk),
        .wr_en   (lwr_en),
        .wr_addr (lwr_addr),
        .wr_data ({lk_reg, z_reg}),
        .rd_addr (lrd_addr),
        .rd_data (lrd_data)
    );

    gsw_ram #(.WIDTH(32), .DEPTH(VDEPTH)) u_vel_ram (
        .clk     (clk),
        .wr_en   (vwr_en),
        .wr_addr (vwr_addr),
        .wr_data (vwr_data),
        .rd_addr (vrd_addr),
        .rd_data (vrd_data)
    );

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    // Stencil column offsets, kept inside the row when not needed
    assign par = r_reg[0];
    assign cm1 = (c_reg != '0) ? c_reg - CIW'(1) : c_reg;
    assign cm2 = (c_reg >= CIW'(2)) ? c_reg - CIW'(2) : c_reg;
    assign cp1 = !lastc_reg ? c_reg + CIW'(1) : c_reg;

    // Which results this item causes
    assign has_up     = (r_reg != '0);
    assign has_left   = has_up && lastr_reg && (c_reg != '0);
    assign has_corner = has_up && lastr_reg && lastc_reg;

    // Line buffer read address per stencil step
    always_comb
    begin
        case (cnt_reg)
            3'd0:    lrd_addr = par ? LAW'(cm1) : LAW'(MAX_COLS) + LAW'(cm1);
            3'd1:    lrd_addr = par ? LAW'(c_reg) : LAW'(MAX_COLS) + LAW'(c_reg);
            3'd2:    lrd_addr = par ? LAW'(cp1) : LAW'(MAX_COLS) + LAW'(cp1);
            3'd3:    lrd_addr = par ? LAW'(MAX_COLS) + LAW'(cm2) : LAW'(cm2);
            3'd4:    lrd_addr = par ? LAW'(MAX_COLS) + LAW'(cm1) : LAW'(cm1);
            default: lrd_addr = par ? LAW'(MAX_COLS) + LAW'(c_reg) : LAW'(c_reg);
        endcase
    end
    assign lwr_addr = par ? LAW'(MAX_COLS) + LAW'(c_reg) : LAW'(c_reg);

    // Select center, neighbor differences and lock for the current job.
    // Stencil slots: 0 up-left, 1 up, 2 up-right, 3 left-left, 4 left, 5 old.
    always_comb
    begin
        case (job_reg)
            JOB_UP:
            begin
                j_ctr  = $signed(lbuf_reg[1][31:0]);
                j_dz   = DZW'(diff33(z_reg, j_ctr))
                       + ((r_reg != RIW'(1)) ? DZW'(diff33($signed(lbuf_reg[5][31:0]), j_ctr))
                                             : DZW'(0))
                       + ((c_reg != '0) ? DZW'(diff33($signed(lbuf_reg[0][31:0]), j_ctr))
                                        : DZW'(0))
                       + (!lastc_reg ? DZW'(diff33($signed(lbuf_reg[2][31:0]), j_ctr))
                                     : DZW'(0));
                j_lock = lbuf_reg[1][32];
                j_rr   = r_reg - RIW'(1);
                j_cc   = c_reg;
            end
            JOB_LEFT:
            begin
                j_ctr  = $signed(lbuf_reg[4][31:0]);
                j_dz   = DZW'(diff33($signed(lbuf_reg[0][31:0]), j_ctr))
                       + ((c_reg > CIW'(1)) ? DZW'(diff33($signed(lbuf_reg[3][31:0]), j_ctr))
                                            : DZW'(0))
                       + DZW'(diff33(z_reg, j_ctr));
                j_lock = lbuf_reg[4][32];
                j_rr   = r_reg;
                j_cc   = c_reg - CIW'(1);
            end
            default:
            begin
                j_ctr  = z_reg;
                j_dz   = DZW'(diff33($signed(lbuf_reg[1][31:0]), z_reg))
                       + ((c_reg != '0) ? DZW'(diff33($signed(lbuf_reg[4][31:0]), z_reg))
                                        : DZW'(0));
                j_lock = lk_reg;
                j_rr   = r_reg;
                j_cc   = c_reg;
            end
        endcase
        j_band = ((ERW + 1)'(j_rr) < (ERW + 1)'(cfg.border_width))
              || ((ECW + 1)'(j_cc) < (ECW + 1)'(cfg.border_width))
              || (((ERW + 1)'(j_rr) + (ERW + 1)'(cfg.border_width)) >= (ERW + 1)'(eff_rows))
              || (((ECW + 1)'(j_cc) + (ECW + 1)'(cfg.border_width)) >= (ECW + 1)'(eff_cols));
        j_vaddr = VAW'(j_rr) * VAW'(MAX_COLS) + VAW'(j_cc);
    end

    // Pick the job that follows the current one
    always_comb
    begin
        case (job_reg)
            JOB_UP:
            begin
                j_more   = has_left || has_corner;
                j_follow = has_left ? JOB_LEFT : JOB_CORNER;
            end
            JOB_LEFT:
            begin
                j_more   = has_corner;
                j_follow = JOB_CORNER;
            end
            default:
            begin
                j_more   = 1'b0;
                j_follow = JOB_CORNER;
            end
        endcase
    end

    // Velocity arithmetic
    assign gain_hi  = cfg.spring_gain[30:FRAC_BITS];
    assign gain_lo  = cfg.spring_gain[FRAC_BITS-1:0];
    assign fric_eff = (cfg.friction_factor > 17'd65536) ? 17'd65536 : cfg.friction_factor;
    assign vsum     = 64'(vel_reg) + 64'(ph_reg) + 64'(pl_reg >>> FRAC_BITS);
    assign vsat     = kill_reg ? 32'sd0 : sat32(vsum);
    assign nv       = fp_reg[FPW-1:FRIC_BITS];
    assign ms       = $signed({18'd0, cfg.min_speed});
    assign nv_st    = ((nv < ms) && (nv > -ms)) ? 32'sd0 : nv[31:0];

    // Next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        z_next         = z_reg;
        lk_next        = lk_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        lastr_next     = lastr_reg;
        lastc_next     = lastc_reg;
        lbuf_next      = lbuf_reg;
        dz_next        = dz_reg;
        ctr_next       = ctr_reg;
        kill_next      = kill_reg;
        fe_next        = fe_reg;
        last_next      = last_reg;
        vaddr_next     = vaddr_reg;
        ph_next        = ph_reg;
        pl_next        = pl_reg;
        vel_next       = vel_reg;
        v_next         = v_reg;
        np_next        = np_reg;
        fp_next        = fp_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        q_pop          = 1'b0;
        lwr_en         = 1'b0;
        vwr_en         = 1'b0;
        vwr_addr       = vaddr_reg;
        vwr_data       = nv_st;
        vrd_addr       = j_vaddr;

        case (state_reg)
            ST_CLEAR:
            begin
                // Zero the velocity store one entry a cycle
                vwr_en   = 1'b1;
                vwr_addr = clr_reg;
                vwr_data = '0;
                clr_next = clr_reg + VAW'(1);
                if (clr_reg == VAW'(VDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    {z_next, lk_next, r_next, c_next, lastr_next, lastc_next} = q_data;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Capture the stencil word issued last cycle
                if (cnt_reg != 3'd0)
                begin
                    lbuf_next[cnt_reg - 3'd1] = lrd_data;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd6)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // Store the new cell in the current row buffer
                lwr_en   = 1'b1;
                job_next = JOB_UP;
                state_next = has_up ? ST_ADDR : ST_IDLE;
            end
            ST_ADDR:
            begin
                dz_next    = j_dz;
                ctr_next   = j_ctr;
                kill_next  = j_lock || j_band;
                fe_next    = (job_reg == JOB_CORNER);
                last_next  = !j_more;
                vaddr_next = j_vaddr;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                ph_next    = PHW'(dz_reg * $signed({1'b0, gain_hi}));
                pl_next    = PLW'(dz_reg * $signed({1'b0, gain_lo}));
                vel_next   = $signed(vrd_data);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                v_next     = vsat;
                np_next    = sat32(64'(ctr_reg) + 64'(vsat));
                state_next = ST_FRIC;
            end
            ST_FRIC:
            begin
                fp_next    = FPW'(v_reg * $signed({1'b0, fric_eff}));
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Write back velocity and hand over the result
                if (out_free)
                begin
                    vwr_en                = 1'b1;
                    out_valid_next        = 1'b1;
                    out_next.new_position = np_reg;
                    out_next.run_last     = last_reg;
                    out_next.frame_end    = fe_reg;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        job_next   = j_follow;
                        state_next = ST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            job_reg       <= JOB_UP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        lk_reg    <= lk_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        lastr_reg <= lastr_next;
        lastc_reg <= lastc_next;
        lbuf_reg  <= lbuf_next;
        dz_reg    <= dz_next;
        ctr_reg   <= ctr_next;
        kill_reg  <= kill_next;
        fe_reg    <= fe_next;
        last_reg  <= last_next;
        vaddr_reg <= vaddr_next;
        ph_reg    <= ph_next;
        pl_reg    <= pl_next;
        vel_reg   <= vel_next;
        v_reg     <= v_next;
        np_reg    <= np_next;
        fp_reg    <= fp_next;
        out_reg   <= out_next;
    end

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid_reg)
        else $error("result during clearing pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside write-back");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_end) |-> out_reg.run_last)
        else $error("frame end result not last of its item");

endmodule

`default_nettype wire

// ----- design/grid_spring_wave_step.sv -----
// ----------------------------------------------------------------------------
// grid_spring_wave_step
// Streaming mass-spring wave step over a raster-ordered grid.
//
// Cells enter on the item channel (item_valid / item_stall), one per beat,
// in raster order. Results leave on the result channel, one row behind the
// input; the final row comes out interleaved with the row above it while
// the final input row arrives. Items of row zero produce no result.
// Registers are written through cfg_write / cfg_index / cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
//
// Each item goes from queue pop through a six-word stencil read and a line
// buffer write, then through the address, multiply, accumulate, friction and
// done steps once for each result it produces (at most three). The stencil
// read goes through the single read port of the line buffer RAM, and the
// shared velocity update unit serves each result in turn. A two-entry queue
// lets the input side take items while the back end works.
// After reset the velocity store is cleared, one entry a cycle, over all
// MAX_ROWS*MAX_COLS entries (4096 by default); item_stall is high meanwhile.
// A stalled result holds in the output register; the velocity unit waits.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_spring_wave_step
    import gsw_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,
    input  wire logic              cfg_write,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data
);

    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int ERW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int ECW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int REC_W = 32 + 1 + RIW + CIW + 2;

    cfg_t cfg_reg, cfg_next;
    logic [ERW-1:0]   eff_rows;
    logic [ECW-1:0]   eff_cols;
    logic             clearing;
    logic             q_push, q_pop, q_full, q_empty;
    logic [REC_W-1:0] q_wdata, q_rdata;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_GRID_ROWS:   cfg_next.grid_rows       = cfg_data[6:0];
                CFG_GRID_COLS:   cfg_next.grid_cols       = cfg_data[6:0];
                CFG_BORDER:      cfg_next.border_width    = cfg_data[5:0];
                CFG_SPRING_GAIN: cfg_next.spring_gain     = cfg_data[30:0];
                CFG_FRICTION:    cfg_next.friction_factor = cfg_data[16:0];
                CFG_MIN_SPEED:   cfg_next.min_speed       = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows       <= 7'd64;
            cfg_reg.grid_cols       <= 7'd64;
            cfg_reg.border_width    <= 6'd0;
            cfg_reg.spring_gain     <= 31'd65536;
            cfg_reg.friction_factor <= 17'd62259;
            cfg_reg.min_speed       <= 16'd7;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Clamp grid size to the supported range
    assign eff_rows = (cfg_reg.grid_rows < 7'd2) ? ERW'(2)
                    : (ERW'(cfg_reg.grid_rows) > ERW'(MAX_ROWS)) ? ERW'(MAX_ROWS)
                    : ERW'(cfg_reg.grid_rows);
    assign eff_cols = (cfg_reg.grid_cols < 7'd2) ? ECW'(2)
                    : (ECW'(cfg_reg.grid_cols) > ECW'(MAX_COLS)) ? ECW'(MAX_COLS)
                    : ECW'(cfg_reg.grid_cols);

    gsw_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .eff_rows   (eff_rows),
        .eff_cols   (eff_cols),
        .clearing   (clearing),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    gsw_queue #(.WIDTH(REC_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    gsw_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .eff_rows     (eff_rows),
        .eff_cols     (eff_cols),
        .clearing     (clearing),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- sim/gsw_checker.sv -----
// ----------------------------------------------------------------------------
// gsw_checker
// Watches the item, result and register ports of the grid spring wave step,
// predicts every result beat from its own copy of the grid state and
// compares each accepted result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gsw_checker
    import gsw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire item_t             item,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire result_t           result,
    input  wire logic              cfg_write,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NR = MAX_ROWS_DEF;
    localparam int NC = MAX_COLS_DEF;

    logic signed [31:0] velocity_mem [NR*NC];
    logic signed [31:0] line_pos [2*NC];
    logic               line_lock [2*NC];
    int unsigned        row_at;
    int unsigned        col_at;
    cfg_t               regs;
    result_t            expected_q [$];

    function automatic int unsigned rows_used();
        if (regs.grid_rows < 2) return 2;
        return (regs.grid_rows > NR) ? NR : regs.grid_rows;
    endfunction

    function automatic int unsigned cols_used();
        if (regs.grid_cols < 2) return 2;
        return (regs.grid_cols > NC) ? NC : regs.grid_cols;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Update one cell's velocity and return its new position
    function automatic logic signed [31:0] spring_update(input int unsigned r,
        input int unsigned c, input logic signed [31:0] z, input longint dz,
        input logic lock);
        longint gh, gl, acc, fr, ms, nv;
        int unsigned idx, bw;
        logic signed [31:0] v;
        gh  = longint'(regs.spring_gain >> FRAC_BITS_DEF);
        gl  = longint'(regs.spring_gain & 31'h0000ffff);
        acc = dz * gh + ((dz * gl) >>> FRAC_BITS_DEF);
        idx = (r % NR) * NC + (c % NC);
        fr  = (regs.friction_factor > 17'd65536) ? 65536 : longint'(regs.friction_factor);
        ms  = longint'(regs.min_speed);
        bw  = regs.border_width;
        v   = clip32(longint'(velocity_mem[idx]) + acc);
        if (lock || r < bw || c < bw || r + bw >= rows_used() || c + bw >= cols_used())
            v = '0;
        nv = (longint'(v) * fr) >>> FRIC_BITS;
        if (nv < ms && nv > -ms)
            nv = 0;
        velocity_mem[idx] = nv[31:0];
        return clip32(longint'(z) + longint'(v));
    endfunction

    // Predict the result beats caused by one item beat
    task automatic predict_cell(input item_t it);
        int unsigned r, c, cb, pb, n0;
        logic last_c, last_r;
        logic signed [31:0] ctr;
        longint dz;
        result_t res;
        r      = row_at % NR;
        c      = col_at % NC;
        last_c = (c + 1 >= cols_used());
        last_r = (r + 1 >= rows_used());
        cb     = (r & 1) * NC;
        pb     = ((r & 1) ^ 1) * NC;
        n0     = expected_q.size();
        if (r > 0)
        begin
            ctr = line_pos[pb + c];
            dz  = longint'(it.position) - ctr;
            if (r > 1) dz += longint'(line_pos[cb + c]) - ctr;
            if (c > 0) dz += longint'(line_pos[pb + c - 1]) - ctr;
            if (!last_c) dz += longint'(line_pos[pb + c + 1]) - ctr;
            res = '{spring_update(r - 1, c, ctr, dz, line_lock[pb + c]), 1'b0, 1'b0};
            expected_q.push_back(res);
        end
        line_pos[cb + c]  = it.position;
        line_lock[cb + c] = it.locked;
        if (r > 0 && last_r)
        begin
            if (c > 0)
            begin
                ctr = line_pos[cb + c - 1];
                dz  = longint'(line_pos[pb + c - 1]) - ctr;
                if (c > 1) dz += longint'(line_pos[cb + c - 2]) - ctr;
                dz += longint'(it.position) - ctr;
                res = '{spring_update(r, c - 1, ctr, dz, line_lock[cb + c - 1]),
                        1'b0, 1'b0};
                expected_q.push_back(res);
            end
            if (last_c)
            begin
                dz = longint'(line_pos[pb + c]) - it.position;
                if (c > 0) dz += longint'(line_pos[cb + c - 1]) - it.position;
                res = '{spring_update(r, c, it.position, dz, it.locked), 1'b0, 1'b1};
                expected_q.push_back(res);
            end
        end
        // mark the last beat of this item
        if (expected_q.size() > n0)
            expected_q[expected_q.size() - 1].run_last = 1'b1;
        if (last_c)
        begin
            col_at = 0;
            row_at = last_r ? 0 : r + 1;
        end
        else
            col_at = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (velocity_mem[i]) velocity_mem[i] = '0;
            foreach (line_pos[i]) line_pos[i] = '0;
            foreach (line_lock[i]) line_lock[i] = 1'b0;
            row_at = 0;
            col_at = 0;
            regs   = '{7'd64, 7'd64, 6'd0, 31'd65536, 17'd62259, 16'd7};
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // track register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GRID_ROWS:   regs.grid_rows       = cfg_data[6:0];
                    CFG_GRID_COLS:   regs.grid_cols       = cfg_data[6:0];
                    CFG_BORDER:      regs.border_width    = cfg_data[5:0];
                    CFG_SPRING_GAIN: regs.spring_gain     = cfg_data[30:0];
                    CFG_FRICTION:    regs.friction_factor = cfg_data[16:0];
                    CFG_MIN_SPEED:   regs.min_speed       = cfg_data[15:0];
                    default: ;
                endcase
            end
            // compare the result beat with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (result.new_position !== want.new_position)
                    begin
                        $display("%0t: new_position expected %h actual %h", $time,
                                 want.new_position, result.new_position);
                        fail_count++;
                    end
                    if (result.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last expected %b actual %b", $time,
                                 want.run_last, result.run_last);
                        fail_count++;
                    end
                    if (result.frame_end !== want.frame_end)
                    begin
                        $display("%0t: frame_end expected %b actual %b", $time,
                                 want.frame_end, result.frame_end);
                        fail_count++;
                    end
                end
            end
            // predict from the item beat
            if (item_valid && !item_stall)
                predict_cell(item);
            pending = expected_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_grid_spring_wave_step.sv -----
// ----------------------------------------------------------------------------
// tb_grid_spring_wave_step
// Drives whole grid frames through the wave step block under a series of
// register settings, with random idle bursts on both channels, a long
// result hold-off and a drain pause; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_spring_wave_step;
    import gsw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG = 20000;
    localparam int SETTLE   = 100;
    localparam int ITEMS    = 370;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;
    logic              cfg_write;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                cells_sent;
    int                idle_cycles;
    bit                quiet;
    bit                hold_req;

    grid_spring_wave_step u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    gsw_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb_grid_spring_wave_step NOT OK");
            $finish;
        end
    end

    // Result side: random stall bursts, and one long hold-off on request
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                result_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Offer one cell and hold it until accepted
    task automatic send_cell(input logic signed [31:0] pos, input logic lock);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_valid    <= 1'b1;
        item.position <= pos;
        item.locked   <= lock;
        do @(posedge clk); while (item_stall);
        cells_sent++;
    endtask

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $urandom_range(0, 32'h200000) - 32'h100000;
        endcase
    endfunction

    // Stream one whole frame of random cells; optionally drain halfway
    task automatic run_frame(input int cells, input bit drain_mid);
        for (int i = 0; i < cells; i++)
        begin
            if (drain_mid && i == cells / 2)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
            // no idling in the last stretch of the run
            quiet = (cells_sent >= ITEMS - 60);
            send_cell(pick_position(), $urandom_range(0, 7) == 0);
        end
    endtask

    // Wait out every expected beat and the pipeline tail
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input int rows, input int cols, input int bw,
                              input int unsigned gain, input int unsigned fric,
                              input int unsigned ms);
        logic [CFG_IW-1:0] idx [7];
        logic [CFG_DW-1:0] val [7];
        idx = '{CFG_GRID_ROWS, CFG_GRID_COLS, CFG_BORDER, CFG_SPRING_GAIN,
                CFG_FRICTION, CFG_MIN_SPEED, CFG_UNUSED};
        val = '{CFG_DW'(rows), CFG_DW'(cols), CFG_DW'(bw), CFG_DW'(gain),
                CFG_DW'(fric), CFG_DW'(ms), CFG_DW'($urandom)};
        for (int k = 0; k < 7; k++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 3))
            0: return $urandom & 32'h7fffffff;
            1: return 32'h7fffffff;
            default: return $urandom_range(0, 32'h30000);
        endcase
    endfunction

    initial
    begin
        int rows, cols, eff_r, eff_c, phase;
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cells_sent  = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest grid, field extremes
        write_regs(2, 2, 0, 65536, 62259, 7);
        send_cell(32'sh7fffffff, 1'b0);
        send_cell(32'sh80000000, 1'b1);
        send_cell(32'sh00000000, 1'b0);
        send_cell(32'shffffffff, 1'b1);
        settle();
        // Band wider than the grid, largest gain
        write_regs(3, 3, 32, 32'h7fffffff, 65536, 0);
        run_frame(9, 1'b0);
        settle();
        // Friction over one, largest minimum speed; row/col below two act as two
        write_regs(1, 0, 0, 32'h7fffffff, 17'h1ffff, 65535);
        send_cell(32'sh80000000, 1'b0);
        send_cell(32'sh7fffffff, 1'b0);
        send_cell(32'sh7fffffff, 1'b0);
        send_cell(32'sh80000000, 1'b0);
        settle();
        // Zero gain and friction
        write_regs(2, 2, 1, 0, 0, 0);
        run_frame(4, 1'b0);
        settle();

        // Widest rows, with a long result hold-off
        write_regs(2, 64, 1, 65536, 62259, 7);
        hold_req = 1'b1;
        run_frame(128, 1'b0);
        settle();
        // Tallest grid, with a drain pause halfway
        write_regs(127, 2, 0, pick_gain(), 65000, 3);
        run_frame(128, 1'b1);
        settle();

        // Random small grids
        phase = 0;
        while (cells_sent < ITEMS)
        begin
            rows  = $urandom_range(0, 7);
            cols  = $urandom_range(0, 7);
            eff_r = (rows < 2) ? 2 : rows;
            eff_c = (cols < 2) ? 2 : cols;
            write_regs(rows, cols, $urandom_range(0, 3), pick_gain(),
                       $urandom_range(0, 17'h1ffff), $urandom_range(0, 65535) >>
                       $urandom_range(0, 16));
            for (int f = 0; f < 2; f++)
                run_frame(eff_r * eff_c, (phase % 5) == 4 && f == 0);
            settle();
            phase++;
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_grid_spring_wave_step OK");
        else
            $display("tb_grid_spring_wave_step NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
